// ===== hw/rtl/wino_pkg.sv =====
// Package with shared types and constants of the Winograd tile unit.
`default_nettype none
package wino_pkg;
  localparam int unsigned ACC_W = 48;
  localparam int unsigned OUT_W = 42;
  localparam int unsigned V_W = 18;
  localparam int unsigned U_W = 20;
  localparam int unsigned SUM_W = 52;
  localparam int unsigned LANES = 16;
  localparam logic [1:0] LAST_ROW = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic clear;
  } lane_ctl_t;
endpackage
`default_nettype wire

// ===== hw/rtl/wino_lane.sv =====
// One lane: multiplies one Winograd-domain pair and accumulates the product.
`default_nettype none
module wino_lane (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire wino_pkg::lane_ctl_t                ctl,
  input  wire logic signed [wino_pkg::V_W-1:0]    v_in,
  input  wire logic signed [wino_pkg::U_W-1:0]    u_in,
  output logic signed [wino_pkg::ACC_W-1:0]       acc
);
  logic signed [wino_pkg::V_W+wino_pkg::U_W-1:0] prod_r;
  logic signed [wino_pkg::ACC_W-1:0] acc_r, acc_nxt;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) prod_r <= v_in * u_in;
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.acc_en) acc_nxt = acc_r + wino_pkg::ACC_W'(prod_r);
    if (ctl.clear) acc_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) acc_r <= '0;
    else acc_r <= acc_nxt;
  end

  assign acc = acc_r;
endmodule
`default_nettype wire

// ===== hw/rtl/wino_merge.sv =====
// Output stage: applies A^T M A over the lane accumulators and scales by one quarter.
`default_nettype none
module wino_merge (
  input  wire logic signed [wino_pkg::ACC_W-1:0] m [wino_pkg::LANES],
  output logic [wino_pkg::OUT_W-1:0]             y [4]
);
  logic signed [wino_pkg::SUM_W-1:0] me [16];
  logic signed [wino_pkg::SUM_W-1:0] a0 [4];
  logic signed [wino_pkg::SUM_W-1:0] a1 [4];
  logic signed [wino_pkg::SUM_W-1:0] s [4];

  always_comb begin
    for (int k = 0; k < 16; k++) me[k] = wino_pkg::SUM_W'(m[k]);
    for (int j = 0; j < 4; j++) begin
      a0[j] = me[j] + me[4+j] + me[8+j];
      a1[j] = me[4+j] - me[8+j] - me[12+j];
    end
    s[0] = a0[0] + a0[1] + a0[2];
    s[1] = a0[1] - a0[2] - a0[3];
    s[2] = a1[0] + a1[1] + a1[2];
    s[3] = a1[1] - a1[2] - a1[3];
    for (int k = 0; k < 4; k++) y[k] = s[k][wino_pkg::OUT_W+1:2];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/winograd_f2x2_3x3_conv_tile_unit.sv =====
// Top level of the Winograd F(2x2,3x3) tile unit.
`default_nettype none
// Rows 0 to 2 of a channel only store. Row 3 forms V and U' into registers,
// then the 16 lanes multiply (ST_MUL) and accumulate (ST_ACC) on them.
// On the last channel the 2x2 result is offered in the cycle after the
// accumulate, straight from the held sums, and the block waits there until it
// is taken. The input is held off from row 3 until that work is done.
module winograd_f2x2_3x3_conv_tile_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int MAX_CHANNELS = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // data_0, data_1, data_2, data_3, weight_0, weight_1, weight_2, row
  input  wire logic [119:0] in_tdata,
  // last_channel
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_00, out_01, out_10, out_11
  output logic [167:0]      out_tdata
);
  localparam int CH_W = $clog2(MAX_CHANNELS + 1);
  localparam int VW = wino_pkg::V_W;
  localparam int UW = wino_pkg::U_W;

  wino_pkg::state_t state_r, state_nxt;
  logic last_r, last_nxt;
  logic [CH_W-1:0] ch_r;
  logic signed [15:0] d_r [12];
  logic signed [15:0] g_r [9];
  logic signed [VW-1:0] v_r [16];
  logic signed [UW-1:0] u_r [16];
  logic signed [wino_pkg::ACC_W-1:0] acc [16];
  logic [wino_pkg::OUT_W-1:0] y [4];
  wino_pkg::lane_ctl_t ctl;

  logic signed [15:0] x [7];
  logic [1:0] row;
  logic in_fire;
  logic signed [VW-1:0] dd [16], t [16], v [16];
  logic signed [UW-1:0] gg [9], gu [12], u [16];

  assign row = in_tdata[113:112];
  assign in_fire = in_tvalid && in_tready;

  always_comb begin
    for (int k = 0; k < 7; k++)
      x[k] = 16'(signed'(in_tdata[16*k +: DATA_WIDTH]));
    for (int k = 0; k < 12; k++) dd[k] = VW'(d_r[k]);
    for (int k = 0; k < 4; k++) dd[12+k] = VW'(x[k]);
    for (int j = 0; j < 4; j++) begin
      t[j]    = dd[j] - dd[8+j];
      t[4+j]  = dd[4+j] + dd[8+j];
      t[8+j]  = dd[8+j] - dd[4+j];
      t[12+j] = dd[4+j] - dd[12+j];
    end
    for (int i = 0; i < 4; i++) begin
      v[4*i]   = t[4*i] - t[4*i+2];
      v[4*i+1] = t[4*i+1] + t[4*i+2];
      v[4*i+2] = t[4*i+2] - t[4*i+1];
      v[4*i+3] = t[4*i+1] - t[4*i+3];
    end
    for (int k = 0; k < 9; k++) gg[k] = UW'(g_r[k]);
    for (int j = 0; j < 3; j++) begin
      gu[j]   = gg[j] <<< 1;
      gu[3+j] = gg[j] + gg[3+j] + gg[6+j];
      gu[6+j] = gg[j] - gg[3+j] + gg[6+j];
      gu[9+j] = gg[6+j] <<< 1;
    end
    for (int i = 0; i < 4; i++) begin
      u[4*i]   = gu[3*i] <<< 1;
      u[4*i+1] = gu[3*i] + gu[3*i+1] + gu[3*i+2];
      u[4*i+2] = gu[3*i] - gu[3*i+1] + gu[3*i+2];
      u[4*i+3] = gu[3*i+2] <<< 1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && row != wino_pkg::LAST_ROW) begin
      for (int k = 0; k < 4; k++) d_r[4*row + k] <= x[k];
      for (int k = 0; k < 3; k++) g_r[3*row + k] <= x[4+k];
    end
    if (in_fire && row == wino_pkg::LAST_ROW) begin
      v_r <= v;
      u_r <= u;
    end
  end

  always_comb begin
    state_nxt = state_r;
    last_nxt = last_r;
    in_tready = 1'b0;
    ctl = '0;
    case (state_r)
      wino_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_fire && row == wino_pkg::LAST_ROW) begin
          state_nxt = wino_pkg::ST_MUL;
          last_nxt = in_tuser;
        end
      end
      wino_pkg::ST_MUL: begin
        ctl.mul_en = 1'b1;
        state_nxt = wino_pkg::ST_ACC;
      end
      wino_pkg::ST_ACC: begin
        ctl.acc_en = 1'b1;
        state_nxt = last_r ? wino_pkg::ST_OUT : wino_pkg::ST_IDLE;
      end
      wino_pkg::ST_OUT: begin
        ctl.clear = 1'b1;
        if (out_tready) state_nxt = wino_pkg::ST_IDLE;
        else ctl.clear = 1'b0;
      end
      default: state_nxt = wino_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wino_pkg::ST_IDLE;
      last_r <= 1'b0;
      ch_r <= '0;
    end else begin
      state_r <= state_nxt;
      last_r <= last_nxt;
      if (ctl.acc_en) ch_r <= last_r ? '0 : ch_r + 1'b1;
    end
  end

  // The sums are cleared only when the result is taken, so they hold it while it waits.
  for (genvar l = 0; l < wino_pkg::LANES; l++) begin : g_lane
    wino_lane u_lane (
      .clk(clk), .rst_n(rst_n), .ctl(ctl),
      .v_in(v_r[l]), .u_in(u_r[l]), .acc(acc[l])
    );
  end

  wino_merge u_merge (.m(acc), .y(y));

  assign out_tvalid = (state_r == wino_pkg::ST_OUT);
  assign out_tdata = {y[3], y[2], y[1], y[0]};

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == wino_pkg::ST_IDLE) else $error("ready outside idle");
  a_mul_acc: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.mul_en |=> ctl.acc_en) else $error("multiply not followed by accumulate");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_row3_mul: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && row == wino_pkg::LAST_ROW |=> ctl.mul_en) else $error("row 3 lost");
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench of the Winograd F(2x2,3x3) tile unit.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_CHANNELS = 330;

  typedef struct packed {
    logic [1:0] row;
    logic signed [15:0] w2, w1, w0;
    logic signed [15:0] d3, d2, d1, d0;
  } row_item_t;

  typedef struct {
    row_item_t fields;
    logic last_channel;
  } pending_row_t;

  typedef struct {
    logic [wino_pkg::OUT_W-1:0] px [4];
  } tile_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [119:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [167:0] out_tdata;

  winograd_f2x2_3x3_conv_tile_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  pending_row_t row_queue[$];
  tile_out_t tile_queue[$];
  int errors = 0;
  int phase = 0;  // 0: sender idles more lightly, 1: swapped, 2: no idling
  bit hold_off = 0;

  // Predictor state.
  longint tile_mem [12];
  longint filt_mem [9];
  logic [wino_pkg::ACC_W-1:0] sums [16];

  function automatic void bt4(input longint x[4], output longint y[4]);
    y[0] = x[0] - x[2]; y[1] = x[1] + x[2];
    y[2] = x[2] - x[1]; y[3] = x[1] - x[3];
  endfunction

  function automatic void g2x(input longint x[3], output longint y[4]);
    y[0] = 2 * x[0]; y[1] = x[0] + x[1] + x[2];
    y[2] = x[0] - x[1] + x[2]; y[3] = 2 * x[2];
  endfunction

  task automatic predict_tile(input pending_row_t it);
    longint d[4][4], g[3][3], t[4][4], v[4][4], gu[4][3], u[4][4];
    longint c4[4], r4[4], c3[3], m[4][4], a[2][4], y[2][2], s;
    logic signed [wino_pkg::ACC_W-1:0] acc;
    tile_out_t res;
    int r;
    r = it.fields.row;
    if (r < 3) begin
      tile_mem[r*4+0] = it.fields.d0; tile_mem[r*4+1] = it.fields.d1;
      tile_mem[r*4+2] = it.fields.d2; tile_mem[r*4+3] = it.fields.d3;
      filt_mem[r*3+0] = it.fields.w0; filt_mem[r*3+1] = it.fields.w1;
      filt_mem[r*3+2] = it.fields.w2;
      return;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) d[i][j] = tile_mem[i*4+j];
      for (int j = 0; j < 3; j++) g[i][j] = filt_mem[i*3+j];
    end
    d[3][0] = it.fields.d0; d[3][1] = it.fields.d1;
    d[3][2] = it.fields.d2; d[3][3] = it.fields.d3;
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 4; i++) c4[i] = d[i][j];
      bt4(c4, r4);
      for (int i = 0; i < 4; i++) t[i][j] = r4[i];
    end
    for (int i = 0; i < 4; i++) begin
      c4 = t[i]; bt4(c4, r4); v[i] = r4;
    end
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) c3[i] = g[i][j];
      g2x(c3, r4);
      for (int i = 0; i < 4; i++) gu[i][j] = r4[i];
    end
    for (int i = 0; i < 4; i++) begin
      c3 = gu[i]; g2x(c3, r4); u[i] = r4;
    end
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        sums[i*4+j] = sums[i*4+j] + wino_pkg::ACC_W'(u[i][j] * v[i][j]);
    if (!it.last_channel) return;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        acc = sums[i*4+j];
        m[i][j] = longint'(acc);
      end
    for (int j = 0; j < 4; j++) begin
      a[0][j] = m[0][j] + m[1][j] + m[2][j];
      a[1][j] = m[1][j] - m[2][j] - m[3][j];
    end
    for (int i = 0; i < 2; i++) begin
      y[i][0] = a[i][0] + a[i][1] + a[i][2];
      y[i][1] = a[i][1] - a[i][2] - a[i][3];
    end
    for (int k = 0; k < 4; k++) begin
      s = y[k/2][k%2] >>> 2;
      res.px[k] = s[wino_pkg::OUT_W-1:0];
    end
    tile_queue.push_back(res);
    for (int k = 0; k < 16; k++) sums[k] = '0;
  endtask

  task automatic report_mismatch(input string what,
                                 input logic [wino_pkg::OUT_W-1:0] got,
                                 input logic [wino_pkg::OUT_W-1:0] want);
    $display("tb_top: mismatch %s got %h expected %h", what, got, want);
    errors++;
  endtask

  function automatic logic signed [15:0] pick_value(input int mode);
    case (mode)
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'(signed'($urandom_range(0, 15)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_channel(input int mode, input bit last, input bit shuffle);
    pending_row_t p;
    for (int r = 0; r < 4; r++) begin
      p.fields.d0 = pick_value(mode); p.fields.d1 = pick_value(mode);
      p.fields.d2 = pick_value(mode); p.fields.d3 = pick_value(mode);
      p.fields.w0 = pick_value(mode); p.fields.w1 = pick_value(mode);
      p.fields.w2 = pick_value(mode);
      p.fields.row = shuffle ? 2'($urandom_range(0, 3)) : 2'(r);
      // Rows 0 to 2 ignore the flag, so it is randomized there.
      p.last_channel = (p.fields.row == wino_pkg::LAST_ROW) ? last : 1'($urandom);
      row_queue.push_back(p);
    end
  endtask

  // Driver.
  pending_row_t cur;
  int gap_pct;
  always @(posedge clk) begin
    gap_pct = (phase == 0) ? 14 : (phase == 1) ? 62 : 0;
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (row_queue.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
          cur = row_queue.pop_front();
          predict_tile(cur);
          in_tdata <= {6'b0, cur.fields};
          in_tuser <= cur.last_channel;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker.
  tile_out_t want;
  int rx_pct;
  int hold_count = 0;
  always @(posedge clk) begin
    rx_pct = (phase == 0) ? 62 : (phase == 1) ? 14 : 0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (tile_queue.size() == 0) begin
          $display("tb_top: unexpected result %h", out_tdata);
          errors++;
        end else begin
          want = tile_queue.pop_front();
          for (int k = 0; k < 4; k++)
            if (out_tdata[k*wino_pkg::OUT_W +: wino_pkg::OUT_W] !== want.px[k])
              report_mismatch($sformatf("out pixel %0d", k),
                              out_tdata[k*wino_pkg::OUT_W +: wino_pkg::OUT_W],
                              want.px[k]);
        end
      end
      if (hold_off && hold_count < 300) begin
        hold_count++;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_pct);
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (row_queue.size() > 0 || in_tvalid || tile_queue.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    for (int k = 0; k < 16; k++) sums[k] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: extremes, a multi-channel sum, last flag on early rows.
    queue_channel(0, 1, 0);
    queue_channel(1, 1, 0);
    queue_channel(2, 0, 0);
    queue_channel(1, 1, 0);
    queue_channel(4, 0, 0);
    queue_channel(0, 1, 0);
    // Pressure: receiver holds off while channels keep coming.
    hold_off = 1;
    for (int c = 0; c < 12; c++) queue_channel(4, 1, 0);
    for (int c = 0; c < RANDOM_CHANNELS; c++) begin
      if (c == RANDOM_CHANNELS / 3) begin
        wait_drained(); phase = 1;
      end
      if (c == 2 * RANDOM_CHANNELS / 3) begin
        wait_drained(); phase = 2;
      end
      // Mostly ordered channels; a few with shuffled rows as noise.
      queue_channel($urandom_range(0, 6), ($urandom_range(0, 2) == 0),
                    ($urandom_range(0, 19) == 0));
    end
    queue_channel(3, 1, 0);
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0 && tile_queue.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
